/* rtl/core/srcm_pkg.sv */
package srcm_pkg;

    // Field widths fixed by the channel definitions
    localparam int FIELD_BITS = 16;
    localparam int CHAN_BITS  = 8;

    // Value bits taken from pixel_value and max_value
    localparam int VALUE_BITS = 16;
    localparam int EFF_BITS   = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    // Hue ramp geometry
    localparam int RAMP_STEPS    = 256;
    localparam int RAMP_SEGMENTS = 6;
    localparam int POS_LIMIT     = RAMP_STEPS * RAMP_SEGMENTS;
    localparam int POS_BITS      = $clog2(POS_LIMIT);
    localparam int STEP_BITS     = $clog2(RAMP_STEPS);
    localparam int SEG_BITS      = POS_BITS - STEP_BITS;
    localparam int PROD_BITS     = EFF_BITS + POS_BITS;

    localparam logic [CHAN_BITS-1:0]  CHAN_FULL = {CHAN_BITS{1'b1}};
    localparam logic [CHAN_BITS-1:0]  CHAN_OFF  = '0;
    localparam logic [FIELD_BITS-1:0] MAX_RESET = FIELD_BITS'(256);

    // Hue segments along the ramp
    typedef enum logic [SEG_BITS-1:0] {
        SEG_RED_YELLOW   = SEG_BITS'(0),
        SEG_YELLOW_GREEN = SEG_BITS'(1),
        SEG_GREEN_CYAN   = SEG_BITS'(2),
        SEG_CYAN_BLUE    = SEG_BITS'(3),
        SEG_BLUE_MAGENTA = SEG_BITS'(4),
        SEG_MAGENTA_RED  = SEG_BITS'(5)
    } t_segment;

    // Data handed from cell to cell along the divider chain
    typedef struct packed {
        logic                valid;
        logic                black;
        logic [EFF_BITS-1:0] m;
        logic [EFF_BITS-1:0] rem;
        logic [POS_BITS-1:0] word;
    } t_cell;

endpackage

/* rtl/core/srcm_if.sv */
// Pixel value channel
interface srcm_pix_if;
    logic                              valid;
    logic                              ready;
    logic [srcm_pkg::FIELD_BITS-1:0]   pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// Color result channel
interface srcm_rgb_if;
    logic                             valid;
    logic                             ready;
    logic [srcm_pkg::CHAN_BITS-1:0]   red;
    logic [srcm_pkg::CHAN_BITS-1:0]   green;
    logic [srcm_pkg::CHAN_BITS-1:0]   blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Register write channel
interface srcm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [srcm_pkg::FIELD_BITS-1:0]   max_value;

    modport source (output valid, output max_value, input ready);
    modport sink   (input valid, input max_value, output ready);
endinterface

/* rtl/core/srcm_div_cell.sv */
module srcm_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  srcm_pkg::t_cell i_cell,
    output srcm_pkg::t_cell o_cell
);

    srcm_pkg::t_cell                 r_cell;
    srcm_pkg::t_cell                 n_cell;
    logic [srcm_pkg::EFF_BITS:0]     w_trial;
    logic [srcm_pkg::EFF_BITS:0]     w_diff;
    logic                            w_ge;

    // Shift in the next dividend bit and try to subtract the divisor
    always_comb begin
        w_trial = {i_cell.rem, i_cell.word[srcm_pkg::POS_BITS-1]};
        w_diff  = w_trial - {1'b0, i_cell.m};
        w_ge    = (w_trial >= {1'b0, i_cell.m});

        n_cell       = i_cell;
        n_cell.rem   = w_ge ? w_diff[srcm_pkg::EFF_BITS-1:0]
                            : w_trial[srcm_pkg::EFF_BITS-1:0];
        n_cell.word  = {i_cell.word[srcm_pkg::POS_BITS-2:0], w_ge};
    end

    // Advance to the neighbor, hold on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

/* rtl/core/srcm_shade.sv */
module srcm_shade (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  srcm_pkg::t_cell                 i_cell,
    output logic                            o_valid,
    output logic [srcm_pkg::CHAN_BITS-1:0]  o_red,
    output logic [srcm_pkg::CHAN_BITS-1:0]  o_green,
    output logic [srcm_pkg::CHAN_BITS-1:0]  o_blue
);

    logic                            r_valid;
    logic [srcm_pkg::CHAN_BITS-1:0]  r_red;
    logic [srcm_pkg::CHAN_BITS-1:0]  r_green;
    logic [srcm_pkg::CHAN_BITS-1:0]  r_blue;
    logic [srcm_pkg::CHAN_BITS-1:0]  n_red;
    logic [srcm_pkg::CHAN_BITS-1:0]  n_green;
    logic [srcm_pkg::CHAN_BITS-1:0]  n_blue;
    logic [srcm_pkg::CHAN_BITS-1:0]  w_x;
    logic [srcm_pkg::CHAN_BITS-1:0]  w_xn;
    srcm_pkg::t_segment              w_seg;

    // Split the ramp position into segment and ramp step
    assign w_seg = srcm_pkg::t_segment'(i_cell.word[srcm_pkg::POS_BITS-1:srcm_pkg::STEP_BITS]);
    assign w_x   = srcm_pkg::CHAN_BITS'(i_cell.word[srcm_pkg::STEP_BITS-1:0]);
    assign w_xn  = srcm_pkg::CHAN_FULL - w_x;

    // Pick the channel ramps for the segment
    always_comb begin
        n_red   = srcm_pkg::CHAN_OFF;
        n_green = srcm_pkg::CHAN_OFF;
        n_blue  = srcm_pkg::CHAN_OFF;
        if (!i_cell.black) begin
            unique case (w_seg)
                srcm_pkg::SEG_RED_YELLOW: begin
                    n_red   = srcm_pkg::CHAN_FULL;
                    n_green = w_x;
                end
                srcm_pkg::SEG_YELLOW_GREEN: begin
                    n_red   = w_xn;
                    n_green = srcm_pkg::CHAN_FULL;
                end
                srcm_pkg::SEG_GREEN_CYAN: begin
                    n_green = srcm_pkg::CHAN_FULL;
                    n_blue  = w_x;
                end
                srcm_pkg::SEG_CYAN_BLUE: begin
                    n_green = w_xn;
                    n_blue  = srcm_pkg::CHAN_FULL;
                end
                srcm_pkg::SEG_BLUE_MAGENTA: begin
                    n_red   = w_x;
                    n_blue  = srcm_pkg::CHAN_FULL;
                end
                srcm_pkg::SEG_MAGENTA_RED: begin
                    n_red   = srcm_pkg::CHAN_FULL;
                    n_blue  = w_xn;
                end
                default: begin
                    n_red   = srcm_pkg::CHAN_OFF;
                end
            endcase
        end
    end

    // Load the output register when it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

/* rtl/core/six_segment_rainbow_colormap_unit.sv */
// Channel   Dir   Payload                        Handshake
// i_pix     in    pixel_value[15:0]              valid/ready
// i_cfg     in    max_value[15:0]                valid/ready, always ready
// o_rgb     out   red[7:0] green[7:0] blue[7:0]  valid/ready
//
// One pixel per clock while results are taken; the path is the entry register, 11 divider
// cells (one quotient bit each) and the output register.
// Reset sets max_value to 256 and clears every stage valid.
// A result not taken stalls the whole chain; i_pix.ready is low exactly then.
module six_segment_rainbow_colormap_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srcm_pix_if.sink    i_pix,
    srcm_cfg_if.sink    i_cfg,
    srcm_rgb_if.source  o_rgb
);

    logic [srcm_pkg::FIELD_BITS-1:0] r_max_value;
    logic                            w_adv;
    logic                            w_out_valid;
    logic [srcm_pkg::EFF_BITS-1:0]   w_v;
    logic [srcm_pkg::EFF_BITS-1:0]   w_m;
    logic [srcm_pkg::PROD_BITS-1:0]  w_prod;
    srcm_pkg::t_cell                 r_front;
    srcm_pkg::t_cell                 n_front;
    srcm_pkg::t_cell                 w_chain [srcm_pkg::POS_BITS+1];

    // Take register writes at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= srcm_pkg::MAX_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_value <= i_cfg.max_value;
        end
    end

    // Advance the chain when the output register is free or being taken
    assign w_adv       = !w_out_valid || o_rgb.ready;
    assign i_pix.ready = w_adv;

    // Scale the value by the ramp length and flag values past the end
    always_comb begin
        w_v    = i_pix.pixel_value[srcm_pkg::EFF_BITS-1:0];
        w_m    = r_max_value[srcm_pkg::EFF_BITS-1:0];
        w_prod = srcm_pkg::PROD_BITS'(w_v) * srcm_pkg::PROD_BITS'(srcm_pkg::POS_LIMIT);

        n_front.valid = i_pix.valid;
        n_front.black = (w_v >= w_m);
        n_front.m     = w_m;
        n_front.rem   = w_prod[srcm_pkg::PROD_BITS-1:srcm_pkg::POS_BITS];
        n_front.word  = w_prod[srcm_pkg::POS_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (w_adv) begin
            r_front <= n_front;
        end
    end

    // Divide by max_value, one quotient bit per cell
    assign w_chain[0] = r_front;

    for (genvar g = 0; g < srcm_pkg::POS_BITS; g++) begin : g_cell
        srcm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // Map the ramp position to a color
    srcm_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_cell  (w_chain[srcm_pkg::POS_BITS]),
        .o_valid (w_out_valid),
        .o_red   (o_rgb.red),
        .o_green (o_rgb.green),
        .o_blue  (o_rgb.blue)
    );

    assign o_rgb.valid = w_out_valid;

endmodule

/* rtl/core/srcm_checker.sv */
module srcm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [srcm_pkg::CHAN_BITS-1:0]  i_red,
    input logic [srcm_pkg::CHAN_BITS-1:0]  i_green,
    input logic [srcm_pkg::CHAN_BITS-1:0]  i_blue
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue)))
        else $error("result dropped or changed while stalled");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Accept pixels exactly when the output side can move
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // Every hue color or black has one channel off
    a_one_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_red == '0 || i_green == '0 || i_blue == '0))
        else $error("color has no channel off");

    // Every hue color has one channel full, black has all off
    a_one_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_red == srcm_pkg::CHAN_FULL || i_green == srcm_pkg::CHAN_FULL ||
                         i_blue == srcm_pkg::CHAN_FULL ||
                         (i_red == '0 && i_green == '0 && i_blue == '0)))
        else $error("color is neither on the ramp nor black");

endmodule

bind six_segment_rainbow_colormap_unit srcm_checker u_srcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);
